### hdl/lock_alarm_controller_assert.svh
// ----------------------------------------------------------------------------
// lock_alarm_controller_assert.svh
// assertion macros shared by the lock and alarm controller modules
// ----------------------------------------------------------------------------
`ifndef LOCK_ALARM_CONTROLLER_ASSERT_SVH
`define LOCK_ALARM_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define LAC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("lac assertion failed");

// consequence expected in the cycle after the trigger
`define LAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lac assertion failed");

`else

`define LAC_ASSERT(label, clk, rst_n, prop)
`define LAC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/lac_pkg.sv
// ----------------------------------------------------------------------------
// lac_pkg
// types, codes and reset constants of the lock and alarm controller
// ----------------------------------------------------------------------------
package lac_pkg;

	localparam int POT_W      = 12;
	localparam int ANGLE_W    = 8;
	localparam int CODE_W     = 14;
	localparam int TIMER_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [2:0] {
		M_LOCKING  = 3'd0,
		M_ARMED    = 3'd1,
		M_ALARM    = 3'd2,
		M_WAIT     = 3'd3,
		M_DISARMED = 3'd4
	} mode_t;

	// command codes
	localparam logic [2:0] CMD_DISARM   = 3'd1;
	localparam logic [2:0] CMD_ARM      = 3'd2;
	localparam logic [2:0] CMD_OPEN     = 3'd3;
	localparam logic [2:0] CMD_CLOSE    = 3'd4;
	localparam logic [2:0] CMD_DIAL     = 3'd5;
	localparam logic [2:0] CMD_RESPONSE = 3'd6;

	// pending request bits
	localparam int RQ_DISARM = 0;
	localparam int RQ_ARM    = 1;
	localparam int RQ_OPEN   = 2;
	localparam int RQ_CLOSE  = 3;
	localparam int RQ_DIAL   = 4;
	localparam int RQ_W      = 5;

	// link message codes
	localparam logic [2:0] MSG_NONE      = 3'd0;
	localparam logic [2:0] MSG_ARMED     = 3'd1;
	localparam logic [2:0] MSG_CHALLENGE = 3'd2;
	localparam logic [2:0] MSG_AUTH_OK   = 3'd3;
	localparam logic [2:0] MSG_AUTH_FAIL = 3'd4;
	localparam logic [2:0] MSG_TOO_MANY  = 3'd5;

	// radio event codes
	localparam logic [1:0] RAD_NONE   = 2'd0;
	localparam logic [1:0] RAD_FORCED = 2'd1;
	localparam logic [1:0] RAD_UNAUTH = 2'd2;

	// reply verdict codes
	localparam logic [1:0] AUTH_NONE = 2'd0;
	localparam logic [1:0] AUTH_OK   = 2'd1;
	localparam logic [1:0] AUTH_FAIL = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TAMPER   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAIL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALARM_P  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_P  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_P   = 3'd5;

	typedef struct packed {
		logic [2:0]        command;
		logic [CODE_W-1:0] response_value;
		logic [POT_W-1:0]  pot_sample;
		logic [CODE_W-1:0] challenge_draw;
		logic              link_connected;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic               green_led;
		logic               red_led;
		logic [ANGLE_W-1:0] servo_angle;
		logic [2:0]         link_message;
		logic [CODE_W-1:0]  challenge_out;
		logic [2:0]         failure_count;
		logic [1:0]         radio_event;
		logic               alarm_ping;
	} out_item_t;

	typedef struct packed {
		logic [POT_W-1:0]   tamper_limit;
		logic [POT_W-1:0]   follow_deadband;
		logic [2:0]         max_failures;
		logic [TIMER_W-1:0] alarm_period_ms;
		logic [TIMER_W-1:0] blink_period_ms;
		logic [7:0]         servo_step_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		tamper_limit:     12'd70,
		follow_deadband:  12'd30,
		max_failures:     3'd3,
		alarm_period_ms:  16'd3000,
		blink_period_ms:  16'd250,
		servo_step_ms:    8'd15
	};

endpackage

### hdl/lac_stream_if.sv
// ----------------------------------------------------------------------------
// lac_stream_if
// valid/ready channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface lac_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/lac_cfg_regs.sv
// ----------------------------------------------------------------------------
// lac_cfg_regs
// configuration register bank written through the plain write port
// ----------------------------------------------------------------------------
module lac_cfg_regs
	import lac_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TAMPER:   cfg_q.tamper_limit <= cfg_data[POT_W-1:0];
				CFG_DEADBAND: cfg_q.follow_deadband <= cfg_data[POT_W-1:0];
				CFG_MAX_FAIL: cfg_q.max_failures <= cfg_data[2:0];
				CFG_ALARM_P:  cfg_q.alarm_period_ms <= cfg_data[TIMER_W-1:0];
				CFG_BLINK_P:  cfg_q.blink_period_ms <= cfg_data[TIMER_W-1:0];
				CFG_STEP_P:   cfg_q.servo_step_ms <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/lac_dial_map.sv
// ----------------------------------------------------------------------------
// lac_dial_map
// scales a pot reading to a servo angle by a constant reciprocal multiply
// ----------------------------------------------------------------------------
module lac_dial_map
	import lac_pkg::*;
#(
	parameter int POT_MAX   = 4095,
	parameter int ANGLE_MAX = 180
) (
	input  logic [POT_W-1:0]   pot,
	output logic [ANGLE_W-1:0] angle
);

	// exact floor(pot * ANGLE_MAX / POT_MAX) for every pot below 2**POT_W
	localparam int SHIFT = POT_W + $clog2(POT_MAX + 1) + 1;
	localparam longint unsigned RECIP =
		((longint'(ANGLE_MAX) << SHIFT) + longint'(POT_MAX) - 1) / longint'(POT_MAX);
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W = POT_W + RECIP_W;

	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] quot;

	assign prod = PROD_W'(pot) * PROD_W'(RECIP);
	assign quot = prod >> SHIFT;
	assign angle = (quot > PROD_W'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX) : quot[ANGLE_W-1:0];

endmodule

### hdl/lac_ctrl.sv
// ----------------------------------------------------------------------------
// lac_ctrl
// controller state and the per-tick update of timers, servo, requests and mode
// ----------------------------------------------------------------------------
`include "lock_alarm_controller_assert.svh"

module lac_ctrl
	import lac_pkg::*;
#(
	parameter int ANGLE_MAX = 180
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  in_item_t           item,
	input  logic [ANGLE_W-1:0] dial_angle,
	input  cfg_t               cfg,
	output out_item_t          result
);

	mode_t              mode_q;
	logic [2:0]         fail_q;
	logic [RQ_W-1:0]    pend_q;
	logic [1:0]         auth_q;
	logic [CODE_W-1:0]  chal_q;
	logic [POT_W-1:0]   door_ref_q;
	logic [POT_W-1:0]   stable_pot_q;
	logic               follow_q;
	logic [ANGLE_W-1:0] angle_q;
	logic [ANGLE_W-1:0] target_q;
	logic [TIMER_W-1:0] step_q;
	logic [TIMER_W-1:0] blink_q;
	logic [TIMER_W-1:0] ping_q;
	logic               level_q;
	logic               first_q;
	logic               red_q;

	mode_t              mode_v;
	logic [2:0]         fail_v;
	logic [RQ_W-1:0]    pend_v;
	logic [1:0]         auth_v;
	logic [CODE_W-1:0]  chal_v;
	logic [POT_W-1:0]   ref_v;
	logic [POT_W-1:0]   sp_v;
	logic               follow_v;
	logic [ANGLE_W-1:0] angle_v;
	logic [ANGLE_W-1:0] target_v;
	logic [TIMER_W-1:0] step_v;
	logic [TIMER_W-1:0] blink_v;
	logic [TIMER_W-1:0] ping_v;
	logic               level_v;
	logic               red_v;
	logic [2:0]         msg_v;
	logic [CODE_W-1:0]  chal_out_v;
	logic [1:0]         radio_v;
	logic               ping_out_v;
	logic               green_v;

	function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] t);
		return (t != '1) ? t + TIMER_W'(1) : t;
	endfunction

	function automatic logic [POT_W-1:0] abs_diff(input logic [POT_W-1:0] a,
			input logic [POT_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	always_comb begin
		ref_v      = first_q ? item.pot_sample : door_ref_q;
		sp_v       = first_q ? item.pot_sample : stable_pot_q;
		step_v     = sat_inc(step_q);
		blink_v    = sat_inc(blink_q);
		ping_v     = sat_inc(ping_q);
		mode_v     = mode_q;
		fail_v     = fail_q;
		pend_v     = pend_q;
		auth_v     = auth_q;
		chal_v     = chal_q;
		follow_v   = follow_q;
		angle_v    = angle_q;
		target_v   = target_q;
		level_v    = level_q;
		red_v      = red_q;
		msg_v      = MSG_NONE;
		chal_out_v = '0;
		radio_v    = RAD_NONE;
		ping_out_v = 1'b0;
		green_v    = 1'b0;

		// servo slew
		if (step_v > TIMER_W'(cfg.servo_step_ms) && angle_v != target_v) begin
			if (angle_v < target_v) begin
				angle_v = angle_v + ANGLE_W'(1);
			end else begin
				angle_v = angle_v - ANGLE_W'(1);
			end
			step_v = '0;
		end

		// command latch
		unique case (item.command)
			CMD_DISARM: pend_v[RQ_DISARM] = 1'b1;
			CMD_ARM:    pend_v[RQ_ARM] = 1'b1;
			CMD_OPEN:   pend_v[RQ_OPEN] = 1'b1;
			CMD_CLOSE:  pend_v[RQ_CLOSE] = 1'b1;
			CMD_DIAL:   pend_v[RQ_DIAL] = 1'b1;
			CMD_RESPONSE: begin
				if (mode_q == M_WAIT) begin
					auth_v = (item.response_value == chal_q) ? AUTH_OK : AUTH_FAIL;
				end
			end
			default: ;
		endcase

		// mode transition
		unique case (mode_q)
			M_LOCKING: begin
				if (angle_v == '0) begin
					ref_v  = item.pot_sample;
					fail_v = '0;
					mode_v = M_ARMED;
					msg_v  = MSG_ARMED;
				end
			end
			M_ARMED, M_ALARM: begin
				if (mode_q == M_ARMED &&
						abs_diff(item.pot_sample, ref_v) > cfg.tamper_limit) begin
					radio_v = RAD_FORCED;
					mode_v  = M_ALARM;
				end else if (pend_v[RQ_DISARM]) begin
					chal_v             = item.challenge_draw;
					msg_v              = MSG_CHALLENGE;
					chal_out_v         = item.challenge_draw;
					pend_v[RQ_DISARM]  = 1'b0;
					fail_v             = '0;
					mode_v             = M_WAIT;
				end
			end
			M_WAIT: begin
				if (auth_v == AUTH_OK) begin
					msg_v    = MSG_AUTH_OK;
					auth_v   = AUTH_NONE;
					fail_v   = '0;
					follow_v = 1'b1;
					mode_v   = M_DISARMED;
				end else if (auth_v == AUTH_FAIL) begin
					auth_v = AUTH_NONE;
					if (fail_v != '1) begin
						fail_v = fail_v + 3'd1;
					end
					if (fail_v >= cfg.max_failures) begin
						msg_v   = MSG_TOO_MANY;
						radio_v = RAD_UNAUTH;
						mode_v  = M_ALARM;
					end else begin
						msg_v = MSG_AUTH_FAIL;
					end
				end
			end
			M_DISARMED: begin
				priority if (pend_v[RQ_ARM]) begin
					pend_v[RQ_ARM] = 1'b0;
					mode_v         = M_LOCKING;
				end else if (pend_v[RQ_OPEN]) begin
					follow_v        = 1'b0;
					target_v        = ANGLE_W'(ANGLE_MAX);
					pend_v[RQ_OPEN] = 1'b0;
				end else if (pend_v[RQ_CLOSE]) begin
					follow_v         = 1'b0;
					target_v         = '0;
					pend_v[RQ_CLOSE] = 1'b0;
				end else if (pend_v[RQ_DIAL]) begin
					follow_v        = 1'b1;
					sp_v            = item.pot_sample;
					pend_v[RQ_DIAL] = 1'b0;
				end else begin
				end
			end
			default: mode_v = M_ARMED;
		endcase

		// mode action
		unique case (mode_v)
			M_LOCKING: begin
				target_v = '0;
				green_v  = 1'b1;
				red_v    = 1'b0;
			end
			M_ARMED: begin
				green_v = 1'b1;
				red_v   = 1'b0;
			end
			M_ALARM: begin
				if (blink_v > cfg.blink_period_ms) begin
					level_v = !level_v;
					red_v   = level_v;
					blink_v = '0;
				end
				if (ping_v > cfg.alarm_period_ms) begin
					ping_out_v = 1'b1;
					ping_v     = '0;
				end
			end
			M_WAIT: begin
				if (blink_v > cfg.blink_period_ms) begin
					level_v = !level_v;
					red_v   = level_v;
					blink_v = '0;
				end
			end
			default: begin
				if (follow_v && abs_diff(item.pot_sample, sp_v) > cfg.follow_deadband) begin
					sp_v     = item.pot_sample;
					target_v = dial_angle;
				end
				red_v = 1'b0;
			end
		endcase

		if (!item.link_connected) begin
			msg_v      = MSG_NONE;
			chal_out_v = '0;
		end
	end

	always_comb begin
		result.mode          = mode_v;
		result.green_led     = green_v;
		result.red_led       = red_v;
		result.servo_angle   = angle_v;
		result.link_message  = msg_v;
		result.challenge_out = chal_out_v;
		result.failure_count = fail_v;
		result.radio_event   = radio_v;
		result.alarm_ping    = ping_out_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_DISARMED;
			fail_q       <= '0;
			pend_q       <= '0;
			auth_q       <= AUTH_NONE;
			chal_q       <= '0;
			door_ref_q   <= '0;
			stable_pot_q <= '0;
			follow_q     <= 1'b1;
			angle_q      <= '0;
			target_q     <= '0;
			step_q       <= '0;
			blink_q      <= '0;
			ping_q       <= '0;
			level_q      <= 1'b0;
			first_q      <= 1'b1;
			red_q        <= 1'b0;
		end else if (en) begin
			mode_q       <= mode_v;
			fail_q       <= fail_v;
			pend_q       <= pend_v;
			auth_q       <= auth_v;
			chal_q       <= chal_v;
			door_ref_q   <= ref_v;
			stable_pot_q <= sp_v;
			follow_q     <= follow_v;
			angle_q      <= angle_v;
			target_q     <= target_v;
			step_q       <= step_v;
			blink_q      <= blink_v;
			ping_q       <= ping_v;
			level_q      <= level_v;
			first_q      <= 1'b0;
			red_q        <= red_v;
		end
	end

	`LAC_ASSERT_NEXT(a_angle_step, clk, arst_n, en,
		(angle_q == $past(angle_q) || angle_q == $past(angle_q) + 8'd1 ||
		angle_q == $past(angle_q) - 8'd1))
	`LAC_ASSERT(a_red_quiet, clk, arst_n,
		(mode_q != M_ALARM && mode_q != M_WAIT) |-> !red_q)
	`LAC_ASSERT_NEXT(a_disarm_taken, clk, arst_n,
		en && mode_q == M_ARMED && mode_v == M_WAIT, !pend_q[RQ_DISARM])

endmodule

### hdl/lock_alarm_controller.sv
// ----------------------------------------------------------------------------
// lock_alarm_controller
// door lock and alarm controller stepped by one millisecond tick per transfer
// ----------------------------------------------------------------------------
// tick channel: one transfer per millisecond, carrying the command, the door pot
// sample, a challenge draw and the link state
// status channel: exactly one result transfer per tick, in tick order
// cfg_we/cfg_index/cfg_data: register writes; the user must make them only while no
// tick is in flight, the block itself does not enforce it; a taken tick is held in
// the input register and its state update then loads the status register
// throughput: one tick per clock while status is taken, set by the input register
// feeding the combinational state update into the status register
// stall: while status is held, one more tick waits in the input register,
// then tick.ready drops until status is taken
// reset: mode disarmed, servo at zero, timers and requests clear; the first
// tick after reset loads both pot references
// ----------------------------------------------------------------------------
`include "lock_alarm_controller_assert.svh"

module lock_alarm_controller
	import lac_pkg::*;
#(
	parameter int POT_MAX   = 4095,
	parameter int ANGLE_MAX = 180
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lac_stream_if.sink            tick,
	lac_stream_if.source          status,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t               cfg;
	logic [ANGLE_W-1:0] dial_c;
	out_item_t          result_c;

	logic               valid_s1;
	in_item_t           item_s1;
	logic [ANGLE_W-1:0] dial_s1;
	logic               out_valid_q;
	out_item_t          out_q;
	logic               adv;
	logic               take;

	lac_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lac_dial_map #(
		.POT_MAX   (POT_MAX),
		.ANGLE_MAX (ANGLE_MAX)
	) u_dial (
		.pot   (tick.data.pot_sample),
		.angle (dial_c)
	);

	lac_ctrl #(
		.ANGLE_MAX (ANGLE_MAX)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.item       (item_s1),
		.dial_angle (dial_s1),
		.cfg        (cfg),
		.result     (result_c)
	);

	assign adv        = valid_s1 && (!out_valid_q || status.ready);
	assign tick.ready = !valid_s1 || adv;
	assign take       = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= tick.data;
			dial_s1 <= dial_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= result_c;
		end
	end

	assign status.valid = out_valid_q;
	assign status.data  = out_q;

	`LAC_ASSERT_NEXT(a_result_loaded, clk, arst_n, adv, status.valid)
	`LAC_ASSERT_NEXT(a_stage_kept, clk, arst_n, valid_s1 && !adv, valid_s1)
	`LAC_ASSERT(a_leds_exclusive, clk, arst_n,
		status.valid |-> !(status.data.green_led && status.data.red_led))

endmodule
